### src/lccg_pkg.sv
package lccg_pkg;

  localparam int STEPS   = 32;
  localparam int ROT_W   = 43;   // rotation x/y, gain keeps |x|,|y| below 2^42
  localparam int ZW      = 33;   // angle accumulator, 2^31 = 180 degrees
  localparam int CS_W    = 42;   // clamped sine/cosine
  localparam int SQ_W    = 62;   // normalized radius squares, below 2^62
  localparam int PROD_W  = 104;  // CS_W + SQ_W
  localparam int PP_W    = 52;   // 21 x 31 partial product
  localparam int HALF_W  = 83;   // partial sum before the final add
  localparam int NRM_W   = 59;   // vector components after normalizing
  localparam int VEC_W   = 62;   // vectoring x/y
  localparam int SQ_LIM  = 62;
  localparam int R_W     = 31;   // result angle 0 .. 2^30

  localparam logic signed [ROT_W-1:0] ROT_X0  = ROT_W'(64'd1 << 40);
  localparam logic signed [ZW-1:0]    QUARTER = ZW'(64'd1 << 30);

  localparam logic CFG_EQUATORIAL = 1'b0;
  localparam logic CFG_POLAR      = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_RADII = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef enum logic [1:0] {
    MODE_CONV,
    MODE_ZERO,
    MODE_QUARTER
  } mode_t;

  typedef struct packed {
    logic       vld;
    logic       kind;
    logic       neg;
    logic [1:0] status;
    mode_t      mode;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return ZW'(v);
  endfunction

endpackage

### src/lccg_radii.sv
module lccg_radii
  import lccg_pkg::*;
#(
  parameter int RADIUS_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [RADIUS_BITS-1:0] cfg_data,
  output logic                   busy,
  output logic                   radii_zero,
  output logic [SQ_W-1:0]        a2s,
  output logic [SQ_W-1:0]        b2s
);

  localparam int SW = 2 * RADIUS_BITS;
  localparam int CW = $clog2(RADIUS_BITS + 1);
  localparam int IW = $clog2(RADIUS_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_NORM
  } state_t;

  state_t                 state;
  logic [RADIUS_BITS-1:0] eq_r;
  logic [RADIUS_BITS-1:0] pol_r;
  logic [SW-1:0]          acc_a;
  logic [SW-1:0]          acc_b;
  logic [CW-1:0]          cnt;

  // squares by shift-add, one multiplier bit a cycle, then a shared
  // one-bit-a-cycle normalize that keeps the ratio
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      eq_r  <= '0;
      pol_r <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_EQUATORIAL) eq_r <= cfg_data;
            else pol_r <= cfg_data;
            cnt   <= '0;
            acc_a <= '0;
            acc_b <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          acc_a <= acc_a + (eq_r[cnt[IW-1:0]] ? (SW'(eq_r) << cnt) : '0);
          acc_b <= acc_b + (pol_r[cnt[IW-1:0]] ? (SW'(pol_r) << cnt) : '0);
          cnt   <= cnt + 1'b1;
          if (cnt == CW'(RADIUS_BITS - 1)) state <= S_NORM;
        end
        S_NORM: begin
          if (((acc_a | acc_b) >> SQ_LIM) != '0) begin
            acc_a <= acc_a >> 1;
            acc_b <= acc_b >> 1;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready  = (state == S_IDLE);
  assign busy       = (state != S_IDLE);
  assign radii_zero = (eq_r == '0) || (pol_r == '0);
  assign a2s        = SQ_W'(acc_a);
  assign b2s        = SQ_W'(acc_b);

endmodule

### src/lccg_front.sv
module lccg_front
  import lccg_pkg::*;
#(
  parameter int ANGLE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_vld,
  input  logic                         kind,
  input  logic signed [ANGLE_BITS-1:0] latitude_in,
  input  logic                         radii_zero,
  output side_t                        side,
  output logic [31:0]                  t
);

  localparam int SH_DN = (ANGLE_BITS > 32) ? ANGLE_BITS - 32 : 0;
  localparam int SH_UP = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
  localparam logic [ANGLE_BITS:0] RND =
    (SH_DN > 0) ? ((ANGLE_BITS+1)'(1) << (SH_DN > 0 ? SH_DN - 1 : 0)) : '0;
  localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic                  neg;
  logic [ANGLE_BITS-1:0] mag;
  logic [ANGLE_BITS:0]   mag_r;
  logic [31:0]           t_next;
  side_t                 side_next;

  always_comb begin
    neg   = latitude_in[ANGLE_BITS-1];
    mag   = neg ? ANGLE_BITS'('0 - latitude_in) : ANGLE_BITS'(latitude_in);
    mag_r = {1'b0, mag} + RND;
    if (SH_DN > 0) t_next = 32'(mag_r >> SH_DN);
    else t_next = 32'(mag) << SH_UP;

    side_next.vld  = in_vld;
    side_next.kind = kind;
    side_next.neg  = neg;
    side_next.mode = MODE_CONV;
    if (radii_zero) begin
      side_next.status = ST_NO_RADII;
      side_next.mode   = MODE_ZERO;
    end else if (mag > QTR) begin
      side_next.status = ST_RANGE;
      side_next.mode   = MODE_ZERO;
    end else begin
      side_next.status = ST_OK;
      if (t_next == '0) side_next.mode = MODE_ZERO;
      else if (t_next >= 32'(QUARTER)) side_next.mode = MODE_QUARTER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) side <= '0;
    else side <= side_next;
    t <= t_next;
  end

endmodule

### src/lccg_rot.sv
module lccg_rot
  import lccg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  side_t                   side_in,
  input  logic [31:0]             t,
  output side_t                   side_out,
  output logic signed [ROT_W-1:0] x_out,
  output logic signed [ROT_W-1:0] y_out
);

  logic signed [ROT_W-1:0] xs [0:STEPS-1];
  logic signed [ROT_W-1:0] ys [0:STEPS-1];
  logic signed [ZW-1:0]    zs [0:STEPS-1];
  side_t                   sd [0:STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [ROT_W-1:0] xi;
    logic signed [ROT_W-1:0] yi;
    logic signed [ZW-1:0]    zi;
    side_t                   si;

    if (i == 0) begin : g_first
      assign xi = ROT_X0;
      assign yi = '0;
      assign zi = ZW'(t);
      assign si = side_in;
    end else begin : g_rest
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign si = sd[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) sd[i] <= '0;
      else sd[i] <= si;
      if (!zi[ZW-1]) begin
        xs[i] <= xi - (yi >>> i);
        ys[i] <= yi + (xi >>> i);
        zs[i] <= zi - atan_entry(i);
      end else begin
        xs[i] <= xi + (yi >>> i);
        ys[i] <= yi - (xi >>> i);
        zs[i] <= zi + atan_entry(i);
      end
    end
  end

  assign side_out = sd[STEPS-1];
  assign x_out    = xs[STEPS-1];
  assign y_out    = ys[STEPS-1];

endmodule

### src/lccg_scale.sv
module lccg_scale
  import lccg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  side_t                   side_in,
  input  logic signed [ROT_W-1:0] x_in,
  input  logic signed [ROT_W-1:0] y_in,
  input  logic [SQ_W-1:0]         a2s,
  input  logic [SQ_W-1:0]         b2s,
  output side_t                   side_out,
  output logic [NRM_W-1:0]        x_out,
  output logic [NRM_W-1:0]        y_out
);

  localparam int NSTEP = 6;

  logic [CS_W-1:0] c;
  logic [CS_W-1:0] s;
  logic [SQ_W-1:0] p;
  logic [SQ_W-1:0] q;

  // partial products: s*p gives y, c*q gives x
  logic [PP_W-1:0]   y_ll, y_lh, y_hl, y_hh, x_ll, x_lh, x_hl, x_hh;
  logic [HALF_W-1:0] y_lo, y_hi, x_lo, x_hi;
  side_t             sd_m, sd_a;

  logic [PROD_W-1:0] xn [0:NSTEP];
  logic [PROD_W-1:0] yn [0:NSTEP];
  side_t             sn [0:NSTEP];

  always_comb begin
    c = x_in[ROT_W-1] ? '0 : CS_W'(x_in);
    s = y_in[ROT_W-1] ? '0 : CS_W'(y_in);
    p = side_in.kind ? b2s : a2s;
    q = side_in.kind ? a2s : b2s;
  end

  always_ff @(posedge clk) begin
    y_ll <= PP_W'(s[20:0])  * PP_W'(p[30:0]);
    y_lh <= PP_W'(s[20:0])  * PP_W'(p[61:31]);
    y_hl <= PP_W'(s[41:21]) * PP_W'(p[30:0]);
    y_hh <= PP_W'(s[41:21]) * PP_W'(p[61:31]);
    x_ll <= PP_W'(c[20:0])  * PP_W'(q[30:0]);
    x_lh <= PP_W'(c[20:0])  * PP_W'(q[61:31]);
    x_hl <= PP_W'(c[41:21]) * PP_W'(q[30:0]);
    x_hh <= PP_W'(c[41:21]) * PP_W'(q[61:31]);

    y_lo <= HALF_W'(y_ll) + (HALF_W'(y_lh) << 31);
    y_hi <= HALF_W'(y_hl) + (HALF_W'(y_hh) << 31);
    x_lo <= HALF_W'(x_ll) + (HALF_W'(x_lh) << 31);
    x_hi <= HALF_W'(x_hl) + (HALF_W'(x_hh) << 31);

    yn[0] <= PROD_W'(y_lo) + (PROD_W'(y_hi) << 21);
    xn[0] <= PROD_W'(x_lo) + (PROD_W'(x_hi) << 21);

    if (rst) begin
      sd_m  <= '0;
      sd_a  <= '0;
      sn[0] <= '0;
    end else begin
      sd_m  <= side_in;
      sd_a  <= sd_m;
      sn[0] <= sd_a;
    end
  end

  // binary normalize: shift both by K = 32,16,..,1 when the larger is at or above 2^(58+K), ending below 2^59
  for (genvar j = 0; j < NSTEP; j++) begin : g_norm
    localparam int K = 32 >> j;
    always_ff @(posedge clk) begin
      if (((xn[j] | yn[j]) >> (NRM_W + K - 1)) != '0) begin
        xn[j+1] <= xn[j] >> K;
        yn[j+1] <= yn[j] >> K;
      end else begin
        xn[j+1] <= xn[j];
        yn[j+1] <= yn[j];
      end
      if (rst) sn[j+1] <= '0;
      else sn[j+1] <= sn[j];
    end
  end

  assign side_out = sn[NSTEP];
  assign x_out    = NRM_W'(xn[NSTEP]);
  assign y_out    = NRM_W'(yn[NSTEP]);

endmodule

### src/lccg_vec.sv
module lccg_vec
  import lccg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  side_t                side_in,
  input  logic [NRM_W-1:0]     x_in,
  input  logic [NRM_W-1:0]     y_in,
  output side_t                side_out,
  output logic signed [ZW-1:0] z_out
);

  logic signed [VEC_W-1:0] xs [0:STEPS-1];
  logic signed [VEC_W-1:0] ys [0:STEPS-1];
  logic signed [ZW-1:0]    zs [0:STEPS-1];
  side_t                   sd [0:STEPS-1];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [VEC_W-1:0] xi;
    logic signed [VEC_W-1:0] yi;
    logic signed [ZW-1:0]    zi;
    side_t                   si;
    logic                    y_pos;

    if (i == 0) begin : g_first
      assign xi = VEC_W'(x_in);
      assign yi = VEC_W'(y_in);
      assign zi = '0;
      assign si = side_in;
    end else begin : g_rest
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
      assign si = sd[i-1];
    end

    assign y_pos = !yi[VEC_W-1] && (yi != '0);

    always_ff @(posedge clk) begin
      if (rst) sd[i] <= '0;
      else sd[i] <= si;
      if (y_pos) begin
        xs[i] <= xi + (yi >>> i);
        ys[i] <= yi - (xi >>> i);
        zs[i] <= zi + atan_entry(i);
      end else begin
        xs[i] <= xi - (yi >>> i);
        ys[i] <= yi + (xi >>> i);
        zs[i] <= zi - atan_entry(i);
      end
    end
  end

  assign side_out = sd[STEPS-1];
  assign z_out    = zs[STEPS-1];

endmodule

### src/latitude_centric_graphic_convert_core.sv
// Accepts one item per cycle while busy is low; start is ignored while busy is high.
// Pipeline: input stage, 32 rotation stages, 9 multiply/normalize stages,
// 32 vectoring stages, output stage. done cannot be held off by the receiver.
// A configuration transfer holds busy high while the radius squares are rebuilt:
// a shift-add multiply of each radius, then a shared normalize of both squares.
// Synchronous reset clears the pipeline valids and sets both radii to zero.
module latitude_centric_graphic_convert_core
  import lccg_pkg::*;
#(
  parameter int ANGLE_BITS  = 32,
  parameter int RADIUS_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic signed [ANGLE_BITS-1:0]  latitude_in,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [RADIUS_BITS-1:0]        cfg_data,
  output logic                          done,
  output logic signed [ANGLE_BITS-1:0]  latitude_out,
  output logic [1:0]                    status
);

  localparam int SH_DN = (ANGLE_BITS > 32) ? ANGLE_BITS - 32 : 0;
  localparam int SH_UP = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;
  localparam logic [31:0] RND_O =
    (SH_UP > 0) ? (32'd1 << (SH_UP > 0 ? SH_UP - 1 : 0)) : '0;
  localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic                    radii_zero;
  logic [SQ_W-1:0]         a2s;
  logic [SQ_W-1:0]         b2s;
  side_t                   side_f, side_r, side_s, side_v;
  logic [31:0]             t;
  logic signed [ROT_W-1:0] rx, ry;
  logic [NRM_W-1:0]        nx, ny;
  logic signed [ZW-1:0]    z;
  logic [R_W-1:0]          r;
  logic [ANGLE_BITS-1:0]   res;
  logic [ANGLE_BITS-1:0]   lat_next;

  lccg_radii #(.RADIUS_BITS(RADIUS_BITS)) u_radii (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .busy       (busy),
    .radii_zero (radii_zero),
    .a2s        (a2s),
    .b2s        (b2s)
  );

  lccg_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_vld      (start && !busy),
    .kind        (kind),
    .latitude_in (latitude_in),
    .radii_zero  (radii_zero),
    .side        (side_f),
    .t           (t)
  );

  lccg_rot u_rot (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side_f),
    .t        (t),
    .side_out (side_r),
    .x_out    (rx),
    .y_out    (ry)
  );

  lccg_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side_r),
    .x_in     (rx),
    .y_in     (ry),
    .a2s      (a2s),
    .b2s      (b2s),
    .side_out (side_s),
    .x_out    (nx),
    .y_out    (ny)
  );

  lccg_vec u_vec (
    .clk      (clk),
    .rst      (rst),
    .side_in  (side_s),
    .x_in     (nx),
    .y_in     (ny),
    .side_out (side_v),
    .z_out    (z)
  );

  always_comb begin
    case (side_v.mode)
      MODE_ZERO:    r = '0;
      MODE_QUARTER: r = R_W'(QUARTER);
      default: begin
        if (z[ZW-1]) r = '0;
        else if (z > QUARTER) r = R_W'(QUARTER);
        else r = R_W'(z);
      end
    endcase
    if (SH_DN > 0) res = ANGLE_BITS'(r) << SH_DN;
    else res = ANGLE_BITS'((32'(r) + RND_O) >> SH_UP);
    if (res > QTR) res = QTR;
    lat_next = side_v.neg ? ANGLE_BITS'('0 - res) : res;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= side_v.vld;
    latitude_out <= lat_next;
    status       <= side_v.status;
  end

endmodule

### src/lccg_checker.sv
module lccg_checker
  import lccg_pkg::*;
#(
  parameter int ANGLE_BITS  = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         busy,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic                         done,
  input logic signed [ANGLE_BITS-1:0] latitude_out,
  input logic [1:0]                   status
);

  localparam logic signed [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NO_RADII || status == ST_RANGE))
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (latitude_out == '0))
    else $error("error result not zero");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |-> (latitude_out <= QTR && latitude_out >= -QTR))
    else $error("result beyond a quarter turn");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> busy)
    else $error("config transfer did not raise busy");

endmodule

bind latitude_centric_graphic_convert_core lccg_checker #(.ANGLE_BITS(ANGLE_BITS)) u_chk (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .done         (done),
  .latitude_out (latitude_out),
  .status       (status)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lccg_pkg::*;

  localparam logic KIND_C2G = 1'b0;
  localparam logic KIND_G2C = 1'b1;
  localparam int LATENCY = 75;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [32:0] QUARTER_CODE = 33'd1 << 30;
  localparam logic [127:0] LIM_SQ = 128'd1 << 62;
  localparam logic [127:0] LIM_VEC = 128'd1 << 59;
  localparam longint ATAN_TAB [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  typedef struct packed {
    logic signed [31:0] lat;
    logic [1:0]         status;
  } lat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic kind = 1'b0;
  logic signed [31:0] latitude_in = '0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic busy, cfg_ready, done;
  logic signed [31:0] latitude_out;
  logic [1:0] status;

  logic [31:0] eq_radius = '0;
  logic [31:0] pol_radius = '0;
  lat_result_t expected_q[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int idle_pct = 0;
  int cycles = 0;

  latitude_centric_graphic_convert_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .latitude_in(latitude_in), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .latitude_out(latitude_out), .status(status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // rotate (2^40,0) by t, scale by radius squares, then vector back to an angle
  function automatic longint ellipse_angle(longint t, logic [63:0] p, logic [63:0] q);
    logic signed [63:0] x, y, z, nx, ny;
    logic [127:0] pw, qw, yw, xw;
    x = 64'sd1 <<< 40;
    y = 0;
    z = t;
    for (int i = 0; i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_TAB[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_TAB[i];
      end
      x = nx; y = ny;
    end
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    pw = {64'd0, p} * {64'd0, p};
    qw = {64'd0, q} * {64'd0, q};
    while (pw >= LIM_SQ || qw >= LIM_SQ) begin
      pw = pw >> 1; qw = qw >> 1;
    end
    yw = {64'd0, y} * {64'd0, pw[63:0]};
    xw = {64'd0, x} * {64'd0, qw[63:0]};
    while (yw >= LIM_VEC || xw >= LIM_VEC) begin
      yw = yw >> 1; xw = xw >> 1;
    end
    x = xw[63:0];
    y = yw[63:0];
    z = 0;
    for (int i = 0; i < 32; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + ATAN_TAB[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - ATAN_TAB[i];
      end
      x = nx; y = ny;
    end
    if (z < 0) z = 0;
    if (z > (64'sd1 <<< 30)) z = 64'sd1 <<< 30;
    return z;
  endfunction

  function automatic lat_result_t convert_latitude(logic k, logic [31:0] lat);
    lat_result_t r;
    logic neg;
    logic [32:0] mag;
    longint ang;
    neg = lat[31];
    mag = neg ? (33'h1_0000_0000 - {1'b0, lat}) : {1'b0, lat};
    r.lat = '0;
    r.status = ST_OK;
    if (eq_radius == 0 || pol_radius == 0) begin
      r.status = ST_NO_RADII;
    end else if (mag > QUARTER_CODE) begin
      r.status = ST_RANGE;
    end else begin
      if (mag == 0) ang = 0;
      else if (mag >= QUARTER_CODE) ang = longint'(QUARTER_CODE);
      else if (k == KIND_C2G) ang = ellipse_angle(longint'(mag), eq_radius, pol_radius);
      else ang = ellipse_angle(longint'(mag), pol_radius, eq_radius);
      r.lat = neg ? -ang[31:0] : ang[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
  endtask

  always @(posedge clk) begin
    lat_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("MISMATCH: result with nothing expected, lat %0d", latitude_out);
      end else begin
        want = expected_q.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (latitude_out !== want.lat) report_mismatch("latitude_out", latitude_out, want.lat);
      end
    end
  end

  // drives one item; start is left high when the next item follows at once
  task automatic send_item(logic k, logic [31:0] lat);
    if (!start) start <= 1'b1;
    kind <= k;
    latitude_in <= lat;
    do @(posedge clk); while (busy);
    expected_q.push_back(convert_latitude(k, lat));
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    wait (expected_q.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_radius(logic idx, logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_EQUATORIAL) eq_radius = value;
    else pol_radius = value;
    cfg_writes++;
  endtask

  task automatic set_radii(logic [31:0] a, logic [31:0] b);
    write_radius(CFG_EQUATORIAL, a);
    write_radius(CFG_POLAR, b);
  endtask

  task automatic send_edge_angles;
    logic [31:0] angles [12] = '{32'h0, 32'h4000_0000, 32'hC000_0000, 32'h4000_0001,
                                 32'hBFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h1, 32'hFFFF_FFFF, 32'h2000_0000, 32'h3FFF_FFFF,
                                 32'hE000_0000};
    foreach (angles[i]) send_item(i[0], angles[i]);
  endtask

  task automatic test_no_radii;
    send_item(KIND_C2G, 32'h1000_0000);
    send_item(KIND_G2C, 32'h8000_0000);
    set_radii(32'd6378137, 32'd0);
    send_item(KIND_C2G, 32'h1000_0000);
  endtask

  task automatic test_directed;
    set_radii(32'd6378137, 32'd6356752);
    send_edge_angles();
    set_radii(32'd1, 32'hFFFF_FFFF);
    send_item(KIND_C2G, 32'h2000_0000);
    send_item(KIND_G2C, 32'hE000_0000);
    set_radii(32'hFFFF_FFFF, 32'd1);
    send_item(KIND_C2G, 32'h2000_0000);
    send_item(KIND_G2C, 32'h0000_0100);
    set_radii(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_C2G, 32'h1234_5678);
    send_item(KIND_G2C, 32'hDCBA_9876);
  endtask

  function automatic logic [31:0] random_angle;
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    if (sel < 85) return $urandom();
    if (sel < 92) return 32'h4000_0000 + $urandom_range(0, 4) - 2;
    return 32'hC000_0000 + $urandom_range(0, 4) - 2;
  endfunction

  function automatic logic [31:0] random_radius;
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return 32'($urandom_range(3000000, 8000000));
    if (sel < 8) return $urandom() | 32'h1;
    return 32'($urandom_range(1, 255));
  endfunction

  task automatic test_random(int pct);
    idle_pct = pct;
    for (int set = 0; set < 4; set++) begin
      set_radii(random_radius(), random_radius());
      repeat (117) send_item(1'($urandom()), random_angle());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_no_radii();
    test_directed();
    test_random(20);
    test_random(64);
    test_random(0);
    drain();
    $display("covered %0d latitudes, %0d results, %0d radius writes", items_sent,
             results_seen, cfg_writes);
    $display("both conversion kinds, range limits, unset and extreme radii");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
src/lccg_pkg.sv
src/lccg_radii.sv
src/lccg_front.sv
src/lccg_rot.sv
src/lccg_scale.sv
src/lccg_vec.sv
src/latitude_centric_graphic_convert_core.sv
src/lccg_checker.sv
tb/sv/testbench.sv
